>>> rtl/gbs_pkg.sv
// ---------------------------------------------------------------------------
// gbs_pkg: shared types and constants for greedy box suppression
// Box and candidate layouts, cell control and the sequencer states.
// ---------------------------------------------------------------------------
package gbs_pkg;

  localparam int unsigned CoordW = 16;
  localparam int unsigned ScoreW = 16;
  localparam int unsigned ClassW = 8;
  localparam int unsigned DataW  = 88;

  localparam logic CfgScoreThr   = 1'b0;
  localparam logic CfgOverlapThr = 1'b1;

  localparam logic [ScoreW-1:0] ScoreThrReset   = 16'd19661;
  localparam logic [ScoreW-1:0] OverlapThrReset = 16'd29491;

  // left edge in the lowest bits
  typedef struct packed {
    logic [CoordW-1:0] bottom;
    logic [CoordW-1:0] right;
    logic [CoordW-1:0] top;
    logic [CoordW-1:0] left;
  } box_t;

  typedef struct packed {
    box_t              box;
    logic [ScoreW-1:0] score;
    logic [ClassW-1:0] cls;
  } cand_t;

  typedef struct packed {
    logic ins;  // sorted insert of a new candidate
    logic shl;  // shift toward the head
  } cell_ctl_t;

  typedef struct packed {
    logic app;  // append at the tail
    logic rot;  // rotate one place toward the head
  } kcell_ctl_t;

  typedef enum logic [2:0] {
    S_LOAD,
    S_NEXT,
    S_CMP,
    S_WAIT,
    S_KEEP,
    S_DROP,
    S_FLUSH
  } state_e;

endpackage

>>> rtl/greedy_box_suppression.sv
// ---------------------------------------------------------------------------
// greedy_box_suppression: greedy non-maximum suppression over one frame
// Keeps candidates ranked by score in a chain of cells, then runs a greedy
// overlap pass against a ring of kept boxes and streams the survivors.
// ---------------------------------------------------------------------------
//  channel  | dir | beat contents
//  s_axis   | in  | one candidate, tlast ends the frame
//  m_axis   | out | one kept box, tlast on the frame's last result
//  cfg      | in  | register write, index 0 score, 1 overlap threshold
//
// A candidate that does not end a frame is ranked into the store on acceptance.
// The closing beat starts the pass: each stored candidate in turn is tested
// against the kept boxes one at a time in the 5-stage overlap unit, then the
// frame is closed. Reset empties the store at once.
// Input is held off during the pass; a stalled output holds the pass.
// ---------------------------------------------------------------------------
module greedy_box_suppression #(
  parameter int unsigned MAX_CANDIDATES = 64
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  // class[7:0] score[23:8] left[39:24] top[55:40] right[71:56] bottom[87:72]
  input  logic [gbs_pkg::DataW-1:0]  s_axis_tdata,
  input  logic                       s_axis_tlast,
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  // class[7:0] score[23:8] left[39:24] top[55:40] right[71:56] bottom[87:72]
  output logic [gbs_pkg::DataW-1:0]  m_axis_tdata,
  output logic                       m_axis_tlast,
  // none_kept[0] overflowed[1]
  output logic [1:0]                 m_axis_tuser,
  input  logic                       cfg_we_i,
  input  logic                       cfg_idx_i,
  input  logic [15:0]                cfg_data_i
);
  import gbs_pkg::*;

  localparam int unsigned N    = MAX_CANDIDATES;
  localparam int unsigned CntW = $clog2(N + 1);

  state_e state_q, state_d;

  logic [15:0]     sthr_q, othr_q;
  logic [CntW-1:0] cnt_q, cnt_d, rem_q, rem_d, kcnt_q, kcnt_d, jcnt_q, jcnt_d;
  logic            ovf_q, ovf_d;
  cand_t           pend_q, pend_d;
  logic            pend_v_q, pend_v_d;
  cand_t           out_q, out_d;
  logic            out_v_q, out_v_d, out_last_q, out_last_d, out_none_q, out_none_d;
  logic            out_ovf_q, out_ovf_d;

  cand_t           in_cand;
  logic            in_acc, pass_score;
  cell_ctl_t       cctl;
  kcell_ctl_t      kctl;
  cand_t           cell_q [N];
  logic            hold   [N];
  box_t            kbox_q [N];
  logic            iou_go, iou_done, iou_over, out_free;

  assign in_cand.cls       = s_axis_tdata[7:0];
  assign in_cand.score     = s_axis_tdata[23:8];
  assign in_cand.box.left  = s_axis_tdata[39:24];
  assign in_cand.box.top   = s_axis_tdata[55:40];
  assign in_cand.box.right = s_axis_tdata[71:56];
  assign in_cand.box.bottom = s_axis_tdata[87:72];

  assign s_axis_tready = (state_q == S_LOAD);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign pass_score    = in_cand.score > sthr_q;
  assign out_free      = !out_v_q || m_axis_tready;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sthr_q <= ScoreThrReset;
      othr_q <= OverlapThrReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgScoreThr:   sthr_q <= cfg_data_i;
        CfgOverlapThr: othr_q <= cfg_data_i;
        default:       sthr_q <= sthr_q;
      endcase
    end
  end

  // sorted candidate chain
  for (genvar k = 0; k < N; k++) begin : g_cell
    gbs_cell u_cell (
      .clk_i       (clk_i),
      .ctl_i       (cctl),
      .occ_i       (CntW'(k) < cnt_q),
      .new_i       (in_cand),
      .prev_i      ((k == 0) ? in_cand : cell_q[(k == 0) ? 0 : k - 1]),
      .prev_hold_i ((k == 0) ? 1'b1 : hold[(k == 0) ? 0 : k - 1]),
      .next_i      ((k == N - 1) ? cand_t'('0) : cell_q[(k == N - 1) ? k : k + 1]),
      .q_o         (cell_q[k]),
      .hold_o      (hold[k])
    );
  end

  // kept-box ring
  for (genvar k = 0; k < N; k++) begin : g_kcell
    gbs_kcell u_kcell (
      .clk_i     (clk_i),
      .ctl_i     (kctl),
      .is_app_i  (CntW'(k) == kcnt_q),
      .is_tail_i (CntW'(k) == kcnt_q - CntW'(1)),
      .new_i     (cell_q[0].box),
      .head_i    (kbox_q[0]),
      .next_i    (kbox_q[(k == N - 1) ? k : k + 1]),
      .q_o       (kbox_q[k])
    );
  end

  gbs_iou u_iou (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .go_i   (iou_go),
    .a_i    (cell_q[0].box),
    .b_i    (kbox_q[0]),
    .thr_i  (othr_q),
    .done_o (iou_done),
    .over_o (iou_over)
  );

  // sequencer
  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    rem_d      = rem_q;
    kcnt_d     = kcnt_q;
    jcnt_d     = jcnt_q;
    ovf_d      = ovf_q;
    pend_d     = pend_q;
    pend_v_d   = pend_v_q;
    out_d      = out_q;
    out_v_d    = out_v_q && !m_axis_tready;
    out_last_d = out_last_q;
    out_none_d = out_none_q;
    out_ovf_d  = out_ovf_q;
    cctl       = '0;
    kctl       = '0;
    iou_go     = 1'b0;
    case (state_q)
      S_LOAD: begin
        if (in_acc) begin
          if (pass_score) begin
            if (cnt_q == CntW'(N)) begin
              ovf_d = 1'b1;
            end else begin
              cctl.ins = 1'b1;
              cnt_d    = cnt_q + CntW'(1);
            end
          end
          if (s_axis_tlast) begin
            rem_d   = cnt_d;
            kcnt_d  = '0;
            state_d = S_NEXT;
          end
        end
      end
      S_NEXT: begin
        jcnt_d = '0;
        if (rem_q == '0) begin
          state_d = S_FLUSH;
        end else if (kcnt_q == '0) begin
          state_d = S_KEEP;
        end else begin
          state_d = S_CMP;
        end
      end
      S_CMP: begin
        iou_go  = 1'b1;
        state_d = S_WAIT;
      end
      S_WAIT: begin
        if (iou_done) begin
          if (iou_over) begin
            state_d = S_DROP;
          end else begin
            kctl.rot = 1'b1;
            jcnt_d   = jcnt_q + CntW'(1);
            state_d  = (jcnt_d == kcnt_q) ? S_KEEP : S_CMP;
          end
        end
      end
      S_KEEP: begin
        if (!pend_v_q || out_free) begin
          if (pend_v_q) begin
            out_d      = pend_q;
            out_v_d    = 1'b1;
            out_last_d = 1'b0;
            out_none_d = 1'b0;
            out_ovf_d  = ovf_q;
          end
          pend_d   = cell_q[0];
          pend_v_d = 1'b1;
          kctl.app = 1'b1;
          kcnt_d   = kcnt_q + CntW'(1);
          cctl.shl = 1'b1;
          rem_d    = rem_q - CntW'(1);
          state_d  = S_NEXT;
        end
      end
      S_DROP: begin
        cctl.shl = 1'b1;
        rem_d    = rem_q - CntW'(1);
        state_d  = S_NEXT;
      end
      S_FLUSH: begin
        if (out_free) begin
          out_d      = pend_v_q ? pend_q : cand_t'('0);
          out_v_d    = 1'b1;
          out_last_d = 1'b1;
          out_none_d = !pend_v_q;
          out_ovf_d  = ovf_q;
          pend_v_d   = 1'b0;
          cnt_d      = '0;
          kcnt_d     = '0;
          ovf_d      = 1'b0;
          state_d    = S_LOAD;
        end
      end
      default: state_d = S_LOAD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_LOAD;
      cnt_q    <= '0;
      rem_q    <= '0;
      kcnt_q   <= '0;
      jcnt_q   <= '0;
      ovf_q    <= 1'b0;
      pend_v_q <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      rem_q    <= rem_d;
      kcnt_q   <= kcnt_d;
      jcnt_q   <= jcnt_d;
      ovf_q    <= ovf_d;
      pend_v_q <= pend_v_d;
      out_v_q  <= out_v_d;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    pend_q     <= pend_d;
    out_q      <= out_d;
    out_last_q <= out_last_d;
    out_none_q <= out_none_d;
    out_ovf_q  <= out_ovf_d;
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = {out_q.box.bottom, out_q.box.right, out_q.box.top,
                          out_q.box.left, out_q.score, out_q.cls};
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tuser  = {out_ovf_q, out_none_q};

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(N)) else $error("store count beyond capacity");

  a_pass_budget: assert property (@(posedge clk_i) disable iff (!rst_ni)
    {1'b0, kcnt_q} + {1'b0, rem_q} <= {1'b0, cnt_q})
    else $error("kept plus remaining exceeds stored");

  a_flush_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FLUSH && out_free) |=> (cnt_q == '0 && !ovf_q && !pend_v_q))
    else $error("store not cleared after frame");

  a_none_blank: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser[0]) |-> (m_axis_tdata == '0 && m_axis_tlast))
    else $error("empty-frame result carries data");

endmodule

>>> rtl/gbs_cell.sv
// ---------------------------------------------------------------------------
// gbs_cell: one slot of the sorted candidate chain
// Makes room for a new candidate by handing its entry down, or passes
// entries toward the head during the suppression pass.
// ---------------------------------------------------------------------------
module gbs_cell (
  input  logic              clk_i,
  input  gbs_pkg::cell_ctl_t ctl_i,
  input  logic              occ_i,
  input  gbs_pkg::cand_t    new_i,
  input  gbs_pkg::cand_t    prev_i,
  input  logic              prev_hold_i,
  input  gbs_pkg::cand_t    next_i,
  output gbs_pkg::cand_t    q_o,
  output logic              hold_o
);
  import gbs_pkg::*;

  cand_t q_q, q_d;

  // keep the entry when it ranks at or above the new one
  assign hold_o = occ_i && (q_q.score >= new_i.score);

  always_comb begin
    q_d = q_q;
    if (ctl_i.ins && !hold_o) begin
      q_d = prev_hold_i ? new_i : prev_i;
    end else if (ctl_i.shl) begin
      q_d = next_i;
    end
  end

  always_ff @(posedge clk_i) begin
    q_q <= q_d;
  end

  assign q_o = q_q;

endmodule

>>> rtl/gbs_kcell.sv
// ---------------------------------------------------------------------------
// gbs_kcell: one slot of the kept-box ring
// Takes an appended box at the tail, or rotates so each kept box reaches
// the head in turn.
// ---------------------------------------------------------------------------
module gbs_kcell (
  input  logic                clk_i,
  input  gbs_pkg::kcell_ctl_t ctl_i,
  input  logic                is_app_i,
  input  logic                is_tail_i,
  input  gbs_pkg::box_t       new_i,
  input  gbs_pkg::box_t       head_i,
  input  gbs_pkg::box_t       next_i,
  output gbs_pkg::box_t       q_o
);
  import gbs_pkg::*;

  box_t q_q, q_d;

  always_comb begin
    q_d = q_q;
    if (ctl_i.app && is_app_i) begin
      q_d = new_i;
    end else if (ctl_i.rot) begin
      q_d = is_tail_i ? head_i : next_i;
    end
  end

  always_ff @(posedge clk_i) begin
    q_q <= q_d;
  end

  assign q_o = q_q;

endmodule

>>> rtl/gbs_iou.sv
// ---------------------------------------------------------------------------
// gbs_iou: pipelined overlap test
// Five stages: spans, products, union, scaled terms, compare.
// ---------------------------------------------------------------------------
module gbs_iou (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          go_i,
  input  gbs_pkg::box_t a_i,
  input  gbs_pkg::box_t b_i,
  input  logic [15:0]   thr_i,
  output logic          done_o,
  output logic          over_o
);
  import gbs_pkg::*;

  logic [4:0]  vld_q;
  logic [15:0] iw_q, ih_q, wa_q, ha_q, wb_q, hb_q;
  logic [31:0] inter_q, aa_q, ab_q, inter3_q;
  logic [32:0] uni_q;
  logic [47:0] lhs_q;
  logic [48:0] rhs_q;
  logic        uz_q, over_q;
  logic [15:0] ixl, ixr, iyt, iyb;

  function automatic logic [15:0] span(input logic [15:0] lo, input logic [15:0] hi);
    return (hi > lo) ? hi - lo : 16'd0;
  endfunction

  assign ixl = (a_i.left   > b_i.left)   ? a_i.left   : b_i.left;
  assign ixr = (a_i.right  < b_i.right)  ? a_i.right  : b_i.right;
  assign iyt = (a_i.top    > b_i.top)    ? a_i.top    : b_i.top;
  assign iyb = (a_i.bottom < b_i.bottom) ? a_i.bottom : b_i.bottom;

  // track beats through the stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[3:0], go_i};
    end
  end

  always_ff @(posedge clk_i) begin
    // spans
    iw_q <= span(ixl, ixr);
    ih_q <= span(iyt, iyb);
    wa_q <= span(a_i.left, a_i.right);
    ha_q <= span(a_i.top, a_i.bottom);
    wb_q <= span(b_i.left, b_i.right);
    hb_q <= span(b_i.top, b_i.bottom);
    // products
    inter_q <= iw_q * ih_q;
    aa_q    <= wa_q * ha_q;
    ab_q    <= wb_q * hb_q;
    // union, never below zero since the overlap fits in each box
    uni_q    <= {1'b0, aa_q} + {1'b0, ab_q} - {1'b0, inter_q};
    inter3_q <= inter_q;
    // scaled terms
    lhs_q <= {inter3_q, 16'd0};
    rhs_q <= thr_i * uni_q;
    uz_q  <= (uni_q == '0);
    // compare
    over_q <= !uz_q && ({1'b0, lhs_q} > rhs_q);
  end

  assign done_o = vld_q[4];
  assign over_o = over_q;

endmodule

>>> verif/tb_greedy_box_suppression.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_greedy_box_suppression: self-checking bench for greedy box suppression
// Streams frames of candidate boxes, predicts the surviving boxes with a
// behavioral score ranking and overlap pass, and checks every output beat.
// ---------------------------------------------------------------------------
module tb_greedy_box_suppression;
  import gbs_pkg::*;

  localparam int unsigned Capacity = 64;

  typedef struct {
    cand_t c;
    bit    last;
    bit    none;
    bit    ovf;
  } kept_beat_t;

  typedef struct {
    cand_t c;
    bit    last;
    bit    typed;     // expected beat given in the row itself
    cand_t exp_c;
    bit    exp_none;
  } stim_row_t;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             s_axis_tvalid = 1'b0;
  logic             s_axis_tready;
  logic [DataW-1:0] s_axis_tdata = '0;
  logic             s_axis_tlast = 1'b0;
  logic             m_axis_tvalid;
  logic             m_axis_tready = 1'b0;
  logic [DataW-1:0] m_axis_tdata;
  logic             m_axis_tlast;
  logic [1:0]       m_axis_tuser;
  logic             cfg_we_i = 1'b0;
  logic             cfg_idx_i = 1'b0;
  logic [15:0]      cfg_data_i = '0;

  greedy_box_suppression #(.MAX_CANDIDATES(Capacity)) dut (.*);

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // predictor state
  logic [15:0] score_thr = ScoreThrReset;
  logic [15:0] overlap_thr = OverlapThrReset;
  cand_t       ranked[$];
  bit          lost_some;
  kept_beat_t  kept_q[$];
  int          err_count;
  bit          calm;       // no idling on either side
  bit          hold_req;   // long receiver hold-off
  bit          row_typed;
  kept_beat_t  row_exp;

  task automatic report(string what, logic [DataW-1:0] got, logic [DataW-1:0] want);
    $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $time);
    err_count++;
  endtask

  function automatic longint unsigned extent(logic [15:0] lo, logic [15:0] hi);
    return (hi > lo) ? longint'(hi - lo) : 0;
  endfunction

  function automatic bit too_close(box_t a, box_t b);
    longint unsigned inter, uni;
    logic [15:0] l, t, r, b2;
    l  = (a.left > b.left) ? a.left : b.left;
    t  = (a.top > b.top) ? a.top : b.top;
    r  = (a.right < b.right) ? a.right : b.right;
    b2 = (a.bottom < b.bottom) ? a.bottom : b.bottom;
    inter = extent(l, r) * extent(t, b2);
    uni = extent(a.left, a.right) * extent(a.top, a.bottom) +
          extent(b.left, b.right) * extent(b.top, b.bottom) - inter;
    if (uni == 0) return 1'b0;
    return (inter * 65536) > (longint'(overlap_thr) * uni);
  endfunction

  // rank one candidate, and on the frame's end run the greedy pass
  task automatic suppress_frame(cand_t c, bit last);
    cand_t      kept[$];
    kept_beat_t kb;
    int         pos;
    bit         keep;
    if (c.score > score_thr) begin
      if (ranked.size() >= Capacity) lost_some = 1'b1;
      else begin
        pos = ranked.size();
        while (pos > 0 && ranked[pos-1].score < c.score) pos--;
        ranked.insert(pos, c);
      end
    end
    if (!last) return;
    foreach (ranked[i]) begin
      keep = 1'b1;
      foreach (kept[j]) if (too_close(ranked[i].box, kept[j].box)) keep = 1'b0;
      if (keep) kept = {kept, ranked[i]};
    end
    if (row_typed) begin
      row_exp.ovf = lost_some;
      kept_q = {kept_q, row_exp};
    end else if (kept.size() == 0) begin
      kb = '{c: '0, last: 1'b1, none: 1'b1, ovf: lost_some};
      kept_q = {kept_q, kb};
    end else begin
      foreach (kept[i]) begin
        kb = '{c: kept[i], last: (i == kept.size() - 1), none: 1'b0, ovf: lost_some};
        kept_q = {kept_q, kb};
      end
    end
    ranked.delete();
    lost_some = 1'b0;
  endtask

  // predict on accepted input beats, check accepted output beats
  always @(posedge clk_i) begin
    kept_beat_t w;
    if (rst_ni && s_axis_tvalid && s_axis_tready)
      suppress_frame(cand_t'(s_axis_tdata), s_axis_tlast);
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (kept_q.size() == 0) report("unexpected beat", m_axis_tdata, '0);
      else begin
        w = kept_q.pop_front();
        if (m_axis_tdata != DataW'(w.c)) report("tdata", m_axis_tdata, DataW'(w.c));
        if (m_axis_tlast != w.last)
          report("tlast", DataW'(m_axis_tlast), DataW'(w.last));
        if (m_axis_tuser[0] != w.none)
          report("none_kept", DataW'(m_axis_tuser[0]), DataW'(w.none));
        if (m_axis_tuser[1] != w.ovf)
          report("overflowed", DataW'(m_axis_tuser[1]), DataW'(w.ovf));
      end
    end
  end

  // receiver: random stall bursts, one long hold-off on request
  initial begin
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        m_axis_tready <= 1'b0;
        repeat (400) @(posedge clk_i);
        hold_req = 1'b0;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
    end
  end

  task automatic send_cand(cand_t c, bit last);
    if (!calm && $urandom_range(0, 7) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= c;
    s_axis_tlast  <= last;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (kept_q.size() != 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);
  endtask

  task automatic write_reg(logic idx, logic [15:0] val);
    drain_results();
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    if (idx == CfgScoreThr) score_thr = val;
    else overlap_thr = val;
  endtask

  function automatic cand_t near_box(int unsigned bx, int unsigned by, bit wild);
    cand_t c;
    int unsigned x, y;
    c.cls = 8'($urandom());
    if (wild) begin
      c.score = 16'($urandom());
      c.box = {$urandom(), $urandom()};
      return c;
    end
    if (score_thr == 16'hFFFF) c.score = 16'($urandom());
    else if ($urandom_range(0, 3) == 0)
      c.score = 16'(score_thr + 1 + ($urandom_range(0, 3) * 8));
    else c.score = 16'($urandom_range(score_thr + 1, 65535));
    if ($urandom_range(0, 9) == 0) c.score = 16'($urandom_range(0, score_thr));
    x = bx + $urandom_range(0, 64);
    y = by + $urandom_range(0, 64);
    c.box.left   = 16'(x);
    c.box.top    = 16'(y);
    c.box.right  = 16'(x + $urandom_range(0, 400));
    c.box.bottom = 16'(y + $urandom_range(0, 400));
    return c;
  endfunction

  // one frame of n candidates around a few cluster centers
  task automatic random_frame(int n);
    int unsigned bx, by;
    for (int i = 0; i < n; i++) begin
      if (i % 4 == 0) begin
        bx = $urandom_range(0, 60000);
        by = $urandom_range(0, 60000);
      end
      send_cand(near_box(bx, by, $urandom_range(0, 19) == 0), i == n - 1);
    end
  endtask

  stim_row_t rows[13] = '{
    // empty frame, score at zero: none kept
    '{'0, 1, 1, '0, 1},
    // all-ones candidate passes straight through
    '{'1, 1, 1, '1, 0},
    // score equal to threshold is dropped
    '{'{box: '{16'd40, 16'd30, 16'd20, 16'd10}, score: ScoreThrReset, cls: 8'd3},
      1, 1, '0, 1},
    // inverted box, zero area, still kept
    '{'{box: '{16'd10, 16'd10, 16'd90, 16'd90}, score: 16'hFFFF, cls: 8'd0},
      1, 1, '{box: '{16'd10, 16'd10, 16'd90, 16'd90}, score: 16'hFFFF, cls: 8'd0}, 0},
    // equal scores, same box, ranked by arrival: both lose to score 50000
    '{'{box: '{16'd200, 16'd200, 16'd100, 16'd100}, score: 16'd40000, cls: 8'd1}, 0, 0, '0, 0},
    '{'{box: '{16'd200, 16'd200, 16'd100, 16'd100}, score: 16'd40000, cls: 8'd2}, 0, 0, '0, 0},
    '{'{box: '{16'd210, 16'd210, 16'd110, 16'd110}, score: 16'd50000, cls: 8'd7}, 0, 0, '0, 0},
    '{'{box: '{16'd900, 16'd900, 16'd800, 16'd800}, score: 16'd20000, cls: 8'd9}, 1, 0, '0, 0},
    // zero-area twins: zero union, both kept
    '{'{box: '{16'd5, 16'd5, 16'd5, 16'd5}, score: 16'd30000, cls: 8'd4}, 0, 0, '0, 0},
    '{'{box: '{16'd5, 16'd5, 16'd5, 16'd5}, score: 16'd30000, cls: 8'd5}, 1, 0, '0, 0},
    // corner extremes and a low score among them
    '{'{box: '{16'hFFFF, 16'hFFFF, 16'h0, 16'h0}, score: 16'd60000, cls: 8'hAA}, 0, 0, '0, 0},
    '{'{box: '{16'hFFFF, 16'hFFFF, 16'h8000, 16'h8000}, score: 16'd61000, cls: 8'h55},
      0, 0, '0, 0},
    '{'{box: '{16'd100, 16'd100, 16'd0, 16'd0}, score: 16'd100, cls: 8'h11}, 1, 0, '0, 0}
  };

  initial begin
    int unsigned sent;
    int          n;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed rows at reset thresholds
    foreach (rows[i]) begin
      row_typed = rows[i].typed;
      row_exp = '{c: rows[i].exp_c, last: 1'b1, none: rows[i].exp_none, ovf: 1'b0};
      send_cand(rows[i].c, rows[i].last);
      if (rows[i].last) begin
        drain_results();
        row_typed = 1'b0;
      end
    end

    // overflow frame while the receiver is held off, then keep offering
    hold_req = 1'b1;
    random_frame(70);
    random_frame(10);

    // sweep threshold settings, extremes included
    write_reg(CfgScoreThr, 16'd0);
    write_reg(CfgOverlapThr, 16'd0);
    sent = 0;
    while (sent < 80) begin
      n = $urandom_range(1, 8);
      random_frame(n);
      sent += n;
    end
    write_reg(CfgOverlapThr, 16'hFFFF);
    random_frame(68);
    for (int i = 0; i < 12; i++) random_frame($urandom_range(1, 6));
    write_reg(CfgScoreThr, 16'hFFFF);
    for (int i = 0; i < 6; i++) random_frame($urandom_range(1, 4));
    write_reg(CfgScoreThr, 16'd8000);
    write_reg(CfgOverlapThr, 16'd20000);
    sent = 0;
    while (sent < 50) begin
      n = $urandom_range(1, 12);
      random_frame(n);
      sent += n;
    end
    // pause until every kept box is out, then carry on
    drain_results();
    write_reg(CfgScoreThr, 16'($urandom()));
    write_reg(CfgOverlapThr, 16'($urandom()));
    for (int i = 0; i < 10; i++) random_frame($urandom_range(1, 10));
    calm = 1'b1;
    for (int i = 0; i < 10; i++) random_frame($urandom_range(1, 8));
    drain_results();
    repeat (50) @(posedge clk_i);

    if (err_count == 0) $display("tb_greedy_box_suppression OK");
    else $display("tb_greedy_box_suppression NOT OK");
    $finish;
  end

  initial begin
    #4000000;
    $display("tb_greedy_box_suppression NOT OK");
    $finish;
  end

endmodule
